// ===== rtl/tmsu_pkg.sv =====
// ----------------------------------------------------------------------------
// tmsu_pkg
// Shared constants, types and helpers of the transform matrix stack unit.
// ----------------------------------------------------------------------------
package tmsu_pkg;

	// Stack and number format
	localparam int STACK_DEPTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
	localparam int SLOT_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int ROW_AW      = 3;
	localparam int STK_AW      = SLOT_W + 3;
	localparam int ACC_W       = 66 - FRAC_BITS;

	// Operation codes
	localparam logic [2:0] MODE_IDENT = 3'd0;
	localparam logic [2:0] MODE_MUL   = 3'd1;
	localparam logic [2:0] MODE_PUSH  = 3'd2;
	localparam logic [2:0] MODE_POP   = 3'd3;
	localparam logic [2:0] MODE_READ  = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);

	typedef logic [3:0][31:0] row_t;

	typedef struct packed {
		logic       vld;
		logic       first;
		logic       last;
		logic [1:0] col;
	} mac_ctl_t;

	// Row r of the identity matrix
	function automatic row_t ident_row(input logic [1:0] r);
		row_t v;
		for (int c = 0; c < 4; c++) begin
			v[c] = (2'(c) == r) ? ONE_FX : 32'd0;
		end
		return v;
	endfunction

endpackage

// ===== rtl/tmsu_if.sv =====
// ----------------------------------------------------------------------------
// tmsu_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface tmsu_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic               which_matrix;
	logic [1:0]         row_index;
	logic signed [31:0] elem0;
	logic signed [31:0] elem1;
	logic signed [31:0] elem2;
	logic signed [31:0] elem3;

	modport source (output valid, mode, which_matrix, row_index, elem0, elem1, elem2,
		elem3, input ready);
	modport sink (input valid, mode, which_matrix, row_index, elem0, elem1, elem2,
		elem3, output ready);
endinterface

interface tmsu_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] out0;
	logic signed [31:0] out1;
	logic signed [31:0] out2;
	logic signed [31:0] out3;

	modport source (output valid, status, out0, out1, out2, out3, input ready);
	modport sink (input valid, status, out0, out1, out2, out3, output ready);
endinterface

// ===== rtl/tmsu_cur_mem.sv =====
// ----------------------------------------------------------------------------
// tmsu_cur_mem
// Current matrices, one row per word, with per-row valid bits that make an
// unwritten or cleared row read as identity.
// ----------------------------------------------------------------------------
module tmsu_cur_mem
	import tmsu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ROW_AW-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [ROW_AW-1:0] wr_addr,
	input  row_t              wr_data,
	input  logic              clr_en,
	input  logic              clr_mat,
	output row_t              rd_data
);

	row_t       mem_q [8];
	row_t       rd_raw_q;
	logic [7:0] vld_q;
	logic       rd_vld_q;
	logic [1:0] rd_row_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_raw_q <= mem_q[rd_addr];
		rd_vld_q <= vld_q[rd_addr];
		rd_row_q <= rd_addr[1:0];
	end

	// Clear rows of one matrix on load identity, mark rows on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < 8; i++) begin
				if (clr_en && (i[2] == clr_mat)) begin
					vld_q[i] <= 1'b0;
				end else if (wr_en && (wr_addr == ROW_AW'(i))) begin
					vld_q[i] <= 1'b1;
				end
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : ident_row(rd_row_q);

endmodule

// ===== rtl/tmsu_stk_mem.sv =====
// ----------------------------------------------------------------------------
// tmsu_stk_mem
// Saved matrices of both stacks, one row per word.
// ----------------------------------------------------------------------------
module tmsu_stk_mem
	import tmsu_pkg::*;
(
	input  logic              clk,
	input  logic [STK_AW-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [STK_AW-1:0] wr_addr,
	input  row_t              wr_data,
	output row_t              rd_data
);

	row_t mem_q [2**STK_AW];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/tmsu_mac.sv =====
// ----------------------------------------------------------------------------
// tmsu_mac
// One product per cycle, floored, accumulated over four terms, saturated.
// ----------------------------------------------------------------------------
module tmsu_mac
	import tmsu_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  mac_ctl_t     ctl,
	input  logic [31:0]  a,
	input  logic [31:0]  b,
	output logic         res_vld,
	output logic [1:0]   res_col,
	output logic [31:0]  res
);

	localparam logic signed [ACC_W-1:0] MAX_V = ACC_W'(64'sh7FFFFFFF);
	localparam logic signed [ACC_W-1:0] MIN_V = ACC_W'(-64'sh80000000);

	logic signed [63:0]      prod_s1;
	mac_ctl_t                ctl_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] sum;

	// Multiply stage
	always_ff @(posedge clk) begin
		prod_s1 <= $signed(a) * $signed(b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	// Floor and accumulate
	assign term = ACC_W'(prod_s1 >>> FRAC_BITS);
	assign sum  = (ctl_s1.first ? '0 : acc_q) + term;

	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			acc_q <= sum;
		end
	end

	// Saturate the finished sum
	always_comb begin
		if (sum > MAX_V) begin
			res = 32'h7FFF_FFFF;
		end else if (sum < MIN_V) begin
			res = 32'h8000_0000;
		end else begin
			res = sum[31:0];
		end
	end

	assign res_vld = ctl_s1.vld & ctl_s1.last;
	assign res_col = ctl_s1.col;

endmodule

// ===== rtl/transform_matrix_stack_unit.sv =====
// ----------------------------------------------------------------------------
// transform_matrix_stack_unit
// Model-view and projection matrices with push-down stacks, row operations.
// Multiply on row 3 runs 4 rows, each as read, load, MAC, drain, write.
// One word in flight at a time; a shared 32x32 multiplier does every product.
// Reset: both matrices identity (row valid bits), both stacks empty.
// ----------------------------------------------------------------------------
module transform_matrix_stack_unit
	import tmsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tmsu_req_if.sink    req,
	tmsu_rsp_if.source  rsp
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_CRD  = 9'b000000010,
		S_CWR  = 9'b000000100,
		S_MRD  = 9'b000001000,
		S_MLD  = 9'b000010000,
		S_MAC  = 9'b000100000,
		S_MDR  = 9'b001000000,
		S_MWR  = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	state_t           state_q;
	logic [2:0]       mode_q;
	logic             w_q;
	logic [1:0]       row_q;
	logic [1:0]       st_q;
	row_t             res_q;
	row_t             op_q [4];
	row_t             a_row_q;
	row_t             new_row_q;
	logic [LVL_W-1:0] lvl_q [2];
	logic [3:0]       cnt_q;
	logic             rsp_vld_q;
	logic [1:0]       rsp_st_q;
	row_t             rsp_data_q;

	logic              acc;
	row_t              cur_rd;
	row_t              stk_rd;
	logic              cur_wr_en;
	row_t              cur_wr_data;
	logic              stk_wr_en;
	logic [STK_AW-1:0] stk_addr;
	mac_ctl_t          mac_ctl;
	logic              mac_vld;
	logic [1:0]        mac_col;
	logic [31:0]       mac_res;
	logic [LVL_W-1:0]  lvl_cur;

	assign acc       = req.valid & req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign lvl_cur   = lvl_q[w_q];
	assign stk_addr  = {w_q, lvl_cur[SLOT_W-1:0], row_q};

	// Memory write selection
	assign cur_wr_en   = ((state_q == S_CWR) && (mode_q == MODE_POP)) || (state_q == S_MWR);
	assign cur_wr_data = (state_q == S_MWR) ? new_row_q : stk_rd;
	assign stk_wr_en   = (state_q == S_CWR) && (mode_q == MODE_PUSH);

	tmsu_cur_mem u_cur (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr ({w_q, row_q}),
		.wr_en   (cur_wr_en),
		.wr_addr ({w_q, row_q}),
		.wr_data (cur_wr_data),
		.clr_en  (acc && (req.mode == MODE_IDENT)),
		.clr_mat (req.which_matrix),
		.rd_data (cur_rd)
	);

	tmsu_stk_mem u_stk (
		.clk     (clk),
		.rd_addr (stk_addr),
		.wr_en   (stk_wr_en),
		.wr_addr (stk_addr),
		.wr_data (cur_rd),
		.rd_data (stk_rd)
	);

	// Issue one product per cycle: column cnt[3:2], term cnt[1:0]
	always_comb begin
		mac_ctl.vld   = (state_q == S_MAC);
		mac_ctl.first = (cnt_q[1:0] == 2'd0);
		mac_ctl.last  = (cnt_q[1:0] == 2'd3);
		mac_ctl.col   = cnt_q[3:2];
	end

	tmsu_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.a       (a_row_q[cnt_q[1:0]]),
		.b       (op_q[cnt_q[1:0]][cnt_q[3:2]]),
		.res_vld (mac_vld),
		.res_col (mac_col),
		.res     (mac_res)
	);

	// Payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_q <= req.mode;
			w_q    <= req.which_matrix;
			res_q  <= '0;
			if (req.mode == MODE_MUL) begin
				op_q[req.row_index] <= {req.elem3, req.elem2, req.elem1, req.elem0};
			end
		end
		if ((state_q == S_CWR) && (mode_q == MODE_READ)) begin
			res_q <= cur_rd;
		end
		if (state_q == S_MLD) begin
			a_row_q <= cur_rd;
		end
		if (mac_vld) begin
			new_row_q[mac_col] <= mac_res;
		end
	end

	// Sequencer, stack levels and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			st_q       <= ST_OK;
			row_q      <= '0;
			cnt_q      <= '0;
			lvl_q[0]   <= '0;
			lvl_q[1]   <= '0;
			rsp_vld_q  <= 1'b0;
			rsp_st_q   <= ST_OK;
			rsp_data_q <= '0;
		end else begin
			if (rsp_vld_q && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						st_q    <= ST_OK;
						row_q   <= req.row_index;
						state_q <= S_FIN;
						case (req.mode)
							MODE_MUL: begin
								if (req.row_index == 2'd3) begin
									row_q   <= 2'd0;
									state_q <= S_MRD;
								end
							end
							MODE_PUSH: begin
								if (lvl_q[req.which_matrix] == LVL_W'(STACK_DEPTH)) begin
									st_q <= ST_FULL;
								end else begin
									row_q   <= 2'd0;
									state_q <= S_CRD;
								end
							end
							MODE_POP: begin
								if (lvl_q[req.which_matrix] == '0) begin
									st_q <= ST_EMPTY;
								end else begin
									lvl_q[req.which_matrix] <= lvl_q[req.which_matrix] - 1'b1;
									row_q   <= 2'd0;
									state_q <= S_CRD;
								end
							end
							MODE_READ: begin
								state_q <= S_CRD;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_CRD: begin
					state_q <= S_CWR;
				end
				S_CWR: begin
					if ((mode_q == MODE_READ) || (row_q == 2'd3)) begin
						if (mode_q == MODE_PUSH) begin
							lvl_q[w_q] <= lvl_cur + 1'b1;
						end
						state_q <= S_FIN;
					end else begin
						row_q   <= row_q + 2'd1;
						state_q <= S_CRD;
					end
				end
				S_MRD: begin
					state_q <= S_MLD;
				end
				S_MLD: begin
					cnt_q   <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= S_MDR;
					end
				end
				S_MDR: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					if (row_q == 2'd3) begin
						state_q <= S_FIN;
					end else begin
						row_q   <= row_q + 2'd1;
						state_q <= S_MRD;
					end
				end
				S_FIN: begin
					// Hand over once the output register is free
					if (!rsp_vld_q || rsp.ready) begin
						rsp_vld_q  <= 1'b1;
						rsp_st_q   <= st_q;
						rsp_data_q <= res_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid  = rsp_vld_q;
	assign rsp.status = rsp_st_q;
	assign rsp.out0   = rsp_data_q[0];
	assign rsp.out1   = rsp_data_q[1];
	assign rsp.out2   = rsp_data_q[2];
	assign rsp.out3   = rsp_data_q[3];

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives command words into the matrix stack unit, predicts each result word
// from a behavioral copy of both matrices and stacks, and compares in order.
// ----------------------------------------------------------------------------
module tb
	import tmsu_pkg::*;
();

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] out0;
		logic [31:0] out1;
		logic [31:0] out2;
		logic [31:0] out3;
	} rsp_word_t;

	// Behavioral matrix stack and queue of predicted result words
	class matrix_scoreboard;
		logic signed [31:0] cur_mat[2][16];
		logic signed [31:0] operand[16];
		logic signed [31:0] saved[2][STACK_DEPTH][16];
		int                 level[2];
		rsp_word_t          pending[$];
		int                 errors;

		function new();
			for (int w = 0; w < 2; w++) begin
				load_ident(w);
				level[w] = 0;
			end
			foreach (operand[e]) operand[e] = 0;
			errors = 0;
		endfunction

		function void load_ident(int w);
			for (int e = 0; e < 16; e++) begin
				cur_mat[w][e] = (e % 5 == 0) ? ONE_FX : 32'sd0;
			end
		endfunction

		// floor(a*b / 2^FRAC_BITS)
		function longint fx_mul(logic signed [31:0] a, logic signed [31:0] b);
			longint p;
			p = longint'(a) * longint'(b);
			return p >>> FRAC_BITS;
		endfunction

		function void note_cmd(logic [2:0] mode, logic w, logic [1:0] row,
				logic signed [31:0] e0, logic signed [31:0] e1,
				logic signed [31:0] e2, logic signed [31:0] e3);
			rsp_word_t          r;
			logic signed [31:0] prod[16];
			longint             acc;
			r = '0;
			case (mode)
				MODE_IDENT: begin
					load_ident(w);
				end
				MODE_MUL: begin
					operand[row*4] = e0;
					operand[row*4+1] = e1;
					operand[row*4+2] = e2;
					operand[row*4+3] = e3;
					if (row == 2'd3) begin
						for (int i = 0; i < 4; i++) begin
							for (int j = 0; j < 4; j++) begin
								acc = 0;
								for (int k = 0; k < 4; k++) begin
									acc += fx_mul(cur_mat[w][i*4+k], operand[k*4+j]);
								end
								if (acc > 64'sd2147483647) acc = 64'sd2147483647;
								if (acc < -64'sd2147483648) acc = -64'sd2147483648;
								prod[i*4+j] = acc[31:0];
							end
						end
						cur_mat[w] = prod;
					end
				end
				MODE_PUSH: begin
					if (level[w] >= STACK_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						saved[w][level[w]] = cur_mat[w];
						level[w]++;
					end
				end
				MODE_POP: begin
					if (level[w] == 0) begin
						r.status = ST_EMPTY;
					end else begin
						level[w]--;
						cur_mat[w] = saved[w][level[w]];
					end
				end
				MODE_READ: begin
					r.out0 = cur_mat[w][row*4];
					r.out1 = cur_mat[w][row*4+1];
					r.out2 = cur_mat[w][row*4+2];
					r.out3 = cur_mat[w][row*4+3];
				end
				default: ;
			endcase
			pending.insert(pending.size(), r);
		endfunction

		function void check_rsp(rsp_word_t got);
			rsp_word_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result word: status %0d", got.status);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				errors++;
			end
			if (got.out0 !== exp.out0) begin
				$error("out0: expected %h, got %h", exp.out0, got.out0);
				errors++;
			end
			if (got.out1 !== exp.out1) begin
				$error("out1: expected %h, got %h", exp.out1, got.out1);
				errors++;
			end
			if (got.out2 !== exp.out2) begin
				$error("out2: expected %h, got %h", exp.out2, got.out2);
				errors++;
			end
			if (got.out3 !== exp.out3) begin
				$error("out3: expected %h, got %h", exp.out3, got.out3);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tmsu_req_if req ();
	tmsu_rsp_if rsp ();

	transform_matrix_stack_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	matrix_scoreboard sb = new();
	bit               rows_written[4];
	int               sink_hold;
	bit               sink_random;

	// Clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Note accepted command words
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) begin
			sb.note_cmd(req.mode, req.which_matrix, req.row_index,
				req.elem0, req.elem1, req.elem2, req.elem3);
		end
	end

	// Check accepted result words
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			sb.check_rsp({rsp.status, rsp.out0, rsp.out1, rsp.out2, rsp.out3});
		end
	end

	// Result side: random stalls, plus one long hold-off
	initial begin
		int gap;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				rsp.ready <= 1'b0;
				sink_hold--;
			end else if (sink_random && rsp.ready && !rsp.valid) begin
				gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0;
				if (gap > 0) begin
					rsp.ready <= 1'b0;
					sink_hold = gap - 1;
				end
			end else begin
				rsp.ready <= 1'b1;
				if (sink_random && rsp.valid && rsp.ready && $urandom_range(0, 2) == 0)
					sink_hold = $urandom_range(0, 12);
			end
		end
	end

	// Send one command word, then an optional idle gap
	task automatic send_word(logic [2:0] mode, logic w, logic [1:0] row,
			logic [31:0] e0, logic [31:0] e1, logic [31:0] e2, logic [31:0] e3,
			int gap);
		req.valid        <= 1'b1;
		req.mode         <= mode;
		req.which_matrix <= w;
		req.row_index    <= row;
		req.elem0        <= e0;
		req.elem1        <= e1;
		req.elem2        <= e2;
		req.elem3        <= e3;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		if (mode == MODE_MUL) rows_written[row] = 1'b1;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom;
			3: return ONE_FX;
			default: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
		endcase
	endfunction

	function automatic int rand_gap();
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
	endfunction

	// Load a full operand matrix; row 3 triggers the multiply
	task automatic send_matrix(logic w, bit no_gaps);
		for (int r = 0; r < 4; r++) begin
			send_word(MODE_MUL, w, 2'(r), rand_elem(), rand_elem(), rand_elem(),
				rand_elem(), no_gaps ? 0 : rand_gap());
		end
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic bit any_row_missing();
		foreach (rows_written[r]) if (!rows_written[r]) return 1'b1;
		return 1'b0;
	endfunction

	// Stimulus
	initial begin
		int       sent;
		int       sel;
		logic     w;
		logic [1:0] row;
		req.valid        <= 1'b0;
		req.mode         <= MODE_IDENT;
		req.which_matrix <= 1'b0;
		req.row_index    <= 2'd0;
		req.elem0        <= '0;
		req.elem1        <= '0;
		req.elem2        <= '0;
		req.elem3        <= '0;
		sink_hold   = 0;
		sink_random = 1'b0;
		arst_n      = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pops on empty stacks, reads of identity, extreme multiplies, push/pop, bad modes
		send_word(MODE_POP, 1'b0, 2'd0, '0, '0, '0, '0, 0);
		send_word(MODE_POP, 1'b1, 2'd3, '0, '0, '0, '0, 0);
		for (int r = 0; r < 4; r++)
			send_word(MODE_READ, 1'b1, 2'(r), '0, '0, '0, '0, 0);
		send_word(MODE_MUL, 1'b0, 2'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 0);
		send_word(MODE_MUL, 1'b0, 2'd1, 32'h80000000, 32'h7fffffff, 32'hffffffff, 0, 0);
		send_word(MODE_MUL, 1'b0, 2'd2, 32'hffffffff, 32'h1, 32'h80000000, 32'h7fffffff, 0);
		send_word(MODE_MUL, 1'b0, 2'd3, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'hffffffff, 0);
		send_word(MODE_MUL, 1'b1, 2'd3, 32'h80000000, 32'h80000000, 32'h7fffffff, 1, 0);
		send_word(MODE_MUL, 1'b0, 2'd3, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 0);
		for (int r = 0; r < 4; r++)
			send_word(MODE_READ, 1'b0, 2'(r), '0, '0, '0, '0, 0);
		send_word(MODE_PUSH, 1'b0, 2'd0, '0, '0, '0, '0, 0);
		send_word(MODE_IDENT, 1'b0, 2'd0, '0, '0, '0, '0, 0);
		send_word(MODE_POP, 1'b0, 2'd0, '0, '0, '0, '0, 0);
		send_word(MODE_READ, 1'b0, 2'd2, '0, '0, '0, '0, 0);
		send_word(3'd5, 1'b1, 2'd1, '1, '1, '1, '1, 0);
		send_word(3'd7, 1'b0, 2'd2, '1, '1, '1, '1, 0);
		sent = 22;

		// Fill model-view stack past full while the result side is held off
		sink_hold = 200;
		for (int i = 0; i <= STACK_DEPTH; i++)
			send_word(MODE_PUSH, 1'b0, 2'(i), '0, '0, '0, '0, 0);
		send_word(MODE_PUSH, 1'b0, 2'd0, '0, '0, '0, '0, 0);
		sent += STACK_DEPTH + 2;
		drain();

		// Random part: mostly well-formed operand loads, pushes, pops and reads
		sink_random = 1'b1;
		while (sent < 950) begin
			w   = $urandom_range(0, 1);
			row = $urandom_range(0, 3);
			sel = $urandom_range(0, 99);
			if (sel < 20) begin
				send_matrix(w, $urandom_range(0, 4) == 0);
				sent += 4;
			end else if (sel < 30 && !any_row_missing()) begin
				send_word(MODE_MUL, w, 2'd3, rand_elem(), rand_elem(), rand_elem(),
					rand_elem(), rand_gap());
				sent++;
			end else if (sel < 34) begin
				send_word(MODE_MUL, w, row == 2'd3 ? 2'd0 : row, rand_elem(), rand_elem(),
					rand_elem(), rand_elem(), rand_gap());
				sent++;
			end else if (sel < 50) begin
				send_word(MODE_PUSH, w, row, $urandom, $urandom, $urandom, $urandom,
					rand_gap());
				sent++;
			end else if (sel < 66) begin
				send_word(MODE_POP, w, row, $urandom, $urandom, $urandom, $urandom,
					rand_gap());
				sent++;
			end else if (sel < 90) begin
				send_word(MODE_READ, w, row, $urandom, $urandom, $urandom, $urandom,
					rand_gap());
				sent++;
			end else if (sel < 96) begin
				send_word(MODE_IDENT, w, row, $urandom, $urandom, $urandom, $urandom,
					rand_gap());
				sent++;
			end else begin
				send_word(3'($urandom_range(5, 7)), w, row, $urandom, $urandom, $urandom,
					$urandom, rand_gap());
				sent++;
			end
			// Pause around 500 words sent until everything has come back
			if (sent >= 500 && sent < 505) drain();
		end

		drain();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Timeout
	initial begin
		#10ms;
		$display("status: fail");
		$finish;
	end

endmodule
